// File: hw/rtl/hkrb_pkg.sv
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared types, codes and the ASCII-to-usage table for the HID keyboard
// report builder.
// ----------------------------------------------------------------------------
package hkrb_pkg;

    localparam int DEF_KEY_SLOTS = 6;
    localparam int OUT_SLOTS     = 6;
    localparam int USAGE_W       = 7;
    localparam int MOD_W         = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0]         RAW_BASE   = 8'd136;
    localparam logic [MOD_W-1:0]   LEFT_SHIFT = 8'h02;

    // Event action codes
    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_ALL     = 2'd2;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_CLEAR,
        OP_PRESS,
        OP_RELEASE
    } hkrb_op_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] key_code;
        logic       link_up;
    } hkrb_event_t;

    typedef struct packed {
        logic               accepted;
        logic               report_sent;
        logic [MOD_W-1:0]   modifiers;
        logic [USAGE_W-1:0] slot_0;
        logic [USAGE_W-1:0] slot_1;
        logic [USAGE_W-1:0] slot_2;
        logic [USAGE_W-1:0] slot_3;
        logic [USAGE_W-1:0] slot_4;
        logic [USAGE_W-1:0] slot_5;
    } hkrb_report_t;

    // Classified event handed from front to back
    typedef struct packed {
        hkrb_op_t           op;
        logic [MOD_W-1:0]   mod_mask;
        logic [USAGE_W-1:0] usage;
        logic               link_up;
    } hkrb_cmd_t;

    // Bit 7 of an entry means left shift; zero means unmapped
    localparam logic [7:0] USAGE_TABLE [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
        8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
        8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
        8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
    };

endpackage

// File: hw/rtl/hkrb_front.sv
// ----------------------------------------------------------------------------
// hkrb_front
// Accepts key events and classifies them into slot/modifier commands.
// ----------------------------------------------------------------------------
module hkrb_front
    import hkrb_pkg::*;
(
    input  logic        keyboard_on,
    input  logic        event_valid,
    output logic        event_stall,
    input  hkrb_event_t event_data,
    input  logic        queue_full,
    output logic        push,
    output hkrb_cmd_t   cmd
);

    logic [7:0]         entry;
    logic [USAGE_W-1:0] raw_usage;

    assign entry       = USAGE_TABLE[event_data.key_code[6:0]];
    assign raw_usage   = USAGE_W'(event_data.key_code - RAW_BASE);
    assign event_stall = queue_full;
    assign push        = event_valid && !queue_full;

    always_comb
    begin
        cmd          = '0;
        cmd.op       = OP_NOP;
        cmd.link_up  = event_data.link_up;
        if (keyboard_on)
        begin
            unique case (event_data.action)
                ACT_ALL:
                begin
                    cmd.op = OP_CLEAR;
                end
                ACT_PRESS, ACT_RELEASE:
                begin
                    cmd.op = (event_data.action == ACT_PRESS) ? OP_PRESS : OP_RELEASE;
                    if (event_data.key_code >= RAW_BASE)
                    begin
                        cmd.usage = raw_usage;
                    end
                    else if (event_data.key_code[7])
                    begin
                        cmd.mod_mask = MOD_W'(1) << event_data.key_code[2:0];
                    end
                    else if (entry == 8'h00)
                    begin
                        // unmapped ASCII: reject
                        cmd.op = OP_NOP;
                    end
                    else
                    begin
                        cmd.mod_mask = entry[7] ? LEFT_SHIFT : '0;
                        cmd.usage    = entry[USAGE_W-1:0];
                    end
                end
                default:
                begin
                    cmd.op = OP_NOP;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/hkrb_queue.sv
// ----------------------------------------------------------------------------
// hkrb_queue
// Short command FIFO between the classifying front and the report back end.
// ----------------------------------------------------------------------------
module hkrb_queue
    import hkrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hkrb_cmd_t push_cmd,
    input  logic      pop,
    output hkrb_cmd_t head_cmd,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hkrb_cmd_t          entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_cmd = entries_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/hkrb_back.sv
// ----------------------------------------------------------------------------
// hkrb_back
// Applies classified commands to the modifier byte and key slots and
// registers the resulting report.
// ----------------------------------------------------------------------------
module hkrb_back
    import hkrb_pkg::*;
#(
    parameter int KEY_SLOTS = DEF_KEY_SLOTS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  hkrb_cmd_t    head_cmd,
    input  logic         queue_empty,
    output logic         pop,
    output logic         report_valid,
    input  logic         report_stall,
    output hkrb_report_t report_data
);

    logic [MOD_W-1:0]   mods_reg;
    logic [MOD_W-1:0]   mods_next;
    logic [USAGE_W-1:0] slots_reg  [KEY_SLOTS];
    logic [USAGE_W-1:0] slots_next [KEY_SLOTS];
    logic [USAGE_W-1:0] shown      [OUT_SLOTS];
    logic               placed;
    logic               accepted;
    logic               valid_reg;
    logic               valid_next;
    hkrb_report_t       report_reg;
    hkrb_report_t       report_next;

    assign pop      = !queue_empty && (!valid_reg || !report_stall);
    assign accepted = (head_cmd.op != OP_NOP);

    always_comb
    begin
        mods_next  = mods_reg;
        slots_next = slots_reg;
        placed     = 1'b0;
        unique case (head_cmd.op)
            OP_CLEAR:
            begin
                mods_next = '0;
                for (int i = 0; i < KEY_SLOTS; i++)
                begin
                    slots_next[i] = '0;
                end
            end
            OP_PRESS:
            begin
                mods_next = mods_reg | head_cmd.mod_mask;
                if (head_cmd.usage != '0)
                begin
                    // fill the first empty slot; drop when full
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        if (!placed && slots_reg[i] == '0)
                        begin
                            slots_next[i] = head_cmd.usage;
                            placed        = 1'b1;
                        end
                    end
                end
            end
            OP_RELEASE:
            begin
                mods_next = mods_reg & ~head_cmd.mod_mask;
                if (head_cmd.usage != '0)
                begin
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        if (slots_reg[i] == head_cmd.usage)
                        begin
                            slots_next[i] = '0;
                        end
                    end
                end
            end
            OP_NOP:
            begin
                mods_next = mods_reg;
            end
            default:
            begin
                mods_next = mods_reg;
            end
        endcase
    end

    for (genvar k = 0; k < OUT_SLOTS; k++)
    begin : g_shown
        if (k < KEY_SLOTS)
        begin : g_live
            assign shown[k] = slots_next[k];
        end
        else
        begin : g_none
            assign shown[k] = '0;
        end
    end

    always_comb
    begin
        report_next             = report_reg;
        valid_next              = valid_reg;
        if (pop)
        begin
            valid_next              = 1'b1;
            report_next.accepted    = accepted;
            report_next.report_sent = accepted && head_cmd.link_up;
            report_next.modifiers   = mods_next;
            report_next.slot_0      = shown[0];
            report_next.slot_1      = shown[1];
            report_next.slot_2      = shown[2];
            report_next.slot_3      = shown[3];
            report_next.slot_4      = shown[4];
            report_next.slot_5      = shown[5];
        end
        else if (!report_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg  <= '0;
            valid_reg <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                mods_reg  <= mods_next;
                slots_reg <= slots_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        report_reg <= report_next;
    end

    assign report_valid = valid_reg;
    assign report_data  = report_reg;

endmodule

// File: hw/rtl/hid_keyboard_report_builder_unit.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_unit
// HID boot keyboard report builder with six-key rollover.
// ----------------------------------------------------------------------------
// Key events come in on event_valid/event_stall/event_data; one report per
// event leaves on report_valid/report_stall/report_data, in order. Each
// report carries whether the event was accepted, whether it went to the host
// (accepted and link up), and the modifier byte and key slots after it.
// cfg_wr_en/cfg_wr_data write keyboard_on (reset 1); write it only when no
// event is in flight.
// The front decodes an event in the cycle of its transfer and writes a
// command into a two-entry queue; the back end applies it to the slot
// registers and loads the report register. One event per cycle is
// sustained while report_stall stays low: the single slot update per
// cycle in the back end sets that rate.
// Reset clears the modifier byte, empties all slots and the queue, and sets
// keyboard_on. While report_stall is high the report holds; the queue takes
// up to two more events, then event_stall rises.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_unit
    import hkrb_pkg::*;
#(
    parameter int KEY_SLOTS = DEF_KEY_SLOTS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         event_valid,
    output logic         event_stall,
    input  hkrb_event_t  event_data,
    output logic         report_valid,
    input  logic         report_stall,
    output hkrb_report_t report_data
);

    logic      keyboard_on_reg;
    logic      push;
    logic      pop;
    logic      queue_empty;
    logic      queue_full;
    hkrb_cmd_t push_cmd;
    hkrb_cmd_t head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyboard_on_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            keyboard_on_reg <= cfg_wr_data;
        end
    end

    hkrb_front u_front (
        .keyboard_on (keyboard_on_reg),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_data  (event_data),
        .queue_full  (queue_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    hkrb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    hkrb_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report_data  (report_data)
    );

endmodule

// File: hw/rtl/hkrb_checker.sv
// ----------------------------------------------------------------------------
// hkrb_checker
// Port-level checks on the report channel of the keyboard report builder.
// ----------------------------------------------------------------------------
module hkrb_checker
    import hkrb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         report_valid,
    input  logic         report_stall,
    input  hkrb_report_t report_data
);

    // Reset drops any pending report
    a_reset_clears: assert property (@(posedge clk) !rst_n |=> !report_valid)
        else $error("report_valid high during reset");

    // A stalled report holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_stall |=> report_valid && $stable(report_data))
        else $error("stalled report changed");

    // Only an accepted event goes to the host
    a_sent_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> (report_data.accepted || !report_data.report_sent))
        else $error("report_sent without accepted");

endmodule

bind hid_keyboard_report_builder_unit hkrb_checker u_hkrb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report_data  (report_data)
);
